[hdl/assert_macros.svh]
// concurrent assertion helpers, compiled out when ASSERT_OFF is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ldo trim assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ldo trim assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hdl/ltcl_pkg.sv]
package ltcl_pkg;

	// field widths
	localparam int ADC_BITS      = 24;
	localparam int TRIM_BITS     = 5;
	localparam int TRIM_SHIFT    = 7;
	localparam int LDO_BITS      = 16;
	localparam int KEY_BITS      = 16;
	localparam int BIN_BITS      = 2;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 24;

	// trim limits
	localparam logic [TRIM_BITS-1:0] TRIM_MAX   = '1;
	localparam logic [TRIM_BITS-1:0] TRIM_RESET = TRIM_BITS'(16);

	// write word constants
	localparam logic [KEY_BITS-1:0] WRITE_KEY   = 16'ha558;
	localparam logic [LDO_BITS-1:0] MASK_FULL   = 16'hffff;
	localparam logic [LDO_BITS-1:0] MASK_BIN2   = 16'hffef;

	// bin mode codes
	localparam logic [BIN_BITS-1:0] BIN_OFF    = 2'd0;
	localparam logic [BIN_BITS-1:0] BIN_FULL   = 2'd1;
	localparam logic [BIN_BITS-1:0] BIN_MASKED = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_STEP   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TOL    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BIN    = 3'd4;

	// register reset values
	localparam logic [ADC_BITS-1:0] TARGET_RESET = 24'd12079595;
	localparam logic [ADC_BITS-1:0] STEP_RESET   = 24'd33554;
	localparam logic [ADC_BITS-1:0] TOL_RESET    = 24'd67109;
	localparam logic [ADC_BITS-1:0] WINDOW_RESET = 24'd603980;
	localparam logic [BIN_BITS-1:0] BIN_RESET    = BIN_FULL;

	typedef struct packed {
		logic [ADC_BITS-1:0] adc_code;
		logic [LDO_BITS-1:0] ldo_reg_now;
	} sample_t;

	typedef struct packed {
		logic                         write_valid;
		logic [KEY_BITS+LDO_BITS-1:0] write_word;
		logic [TRIM_BITS-1:0]         trim_value;
		logic                         done_res;
		logic                         fail;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_LOAD
	} ltcl_state_t;

	typedef enum logic {
		PH_ADJUST,
		PH_CHECK
	} phase_t;

endpackage

[hdl/ltcl_sdiv.sv]
module ltcl_sdiv (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ltcl_pkg::ADC_BITS-1:0] dividend,
	input  logic [ltcl_pkg::ADC_BITS-1:0] divisor,
	output logic                          done,
	output logic [ltcl_pkg::ADC_BITS-1:0] quotient
);
	import ltcl_pkg::*;

	localparam int CNT_W = $clog2(ADC_BITS);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(ADC_BITS - 1);

	logic                run_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [ADC_BITS-1:0] rem_q;
	logic [ADC_BITS-1:0] dvd_q;
	logic [ADC_BITS-1:0] dsr_q;
	logic [ADC_BITS+1:0] trial;
	logic                qbit;

	// one quotient bit per cycle, restoring
	always_comb begin
		trial = {1'b0, rem_q, dvd_q[ADC_BITS-1]} - {2'b00, dsr_q};
		qbit  = ~trial[ADC_BITS+1];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (run_q) begin
			if (qbit) begin
				rem_q <= trial[ADC_BITS-1:0];
			end else begin
				rem_q <= {rem_q[ADC_BITS-2:0], dvd_q[ADC_BITS-1]};
			end
			dvd_q <= {dvd_q[ADC_BITS-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

[hdl/ldo_trim_calibration_loop.sv]
// adjust sample: the accepting edge loads the divider, which shifts out the quotient bits
// one at a time; then the trim is updated, and then the output register is loaded; check
// sample: the accepting edge enters the load state, which loads the output register
// one sample in flight; the next is taken once the state returns to idle after the
// result load, so a sample is held longer while the output is stalled
// reset: registers at defaults, trim 16, adjust phase, no result pending
`include "assert_macros.svh"

module ldo_trim_calibration_loop (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ltcl_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [ltcl_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  ltcl_pkg::sample_t                  sample,
	output logic                               result_valid,
	input  logic                               result_stall,
	output ltcl_pkg::result_t                  result
);
	import ltcl_pkg::*;

	// configuration registers
	logic [ADC_BITS-1:0] target_q;
	logic [ADC_BITS-1:0] step_q;
	logic [ADC_BITS-1:0] tol_q;
	logic [ADC_BITS-1:0] window_q;
	logic [BIN_BITS-1:0] bin_q;

	// loop state
	ltcl_state_t          state_q, state_d;
	phase_t               phase_q;
	logic [TRIM_BITS-1:0] trim_q;

	// captured sample
	logic [ADC_BITS-1:0]  mag_q;
	logic                 neg_q;
	logic [LDO_BITS-1:0]  ldo_q;

	// output register
	result_t              result_q;
	logic                 result_valid_q;

	logic                 accept;
	logic                 div_start;
	logic                 div_done;
	logic                 trim_we;
	logic                 load;
	logic                 out_free;
	logic [ADC_BITS:0]    diff;
	logic                 neg;
	logic [ADC_BITS-1:0]  mag;
	logic [ADC_BITS-1:0]  step_eff;
	logic [ADC_BITS-1:0]  quot;
	logic [TRIM_BITS:0]   q_cap;
	logic [TRIM_BITS:0]   sum;
	logic [TRIM_BITS-1:0] trim_d;
	logic [LDO_BITS-1:0]  merged;
	logic [LDO_BITS-1:0]  bmask;
	logic                 wr_en;
	result_t              res_d;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
			step_q   <= STEP_RESET;
			tol_q    <= TOL_RESET;
			window_q <= WINDOW_RESET;
			bin_q    <= BIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TARGET: target_q <= cfg_data[ADC_BITS-1:0];
				CFG_STEP:   step_q   <= cfg_data[ADC_BITS-1:0];
				CFG_TOL:    tol_q    <= cfg_data[ADC_BITS-1:0];
				CFG_WINDOW: window_q <= cfg_data[ADC_BITS-1:0];
				CFG_BIN:    bin_q    <= cfg_data[BIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// error magnitude and sign of the incoming sample
	always_comb begin
		diff     = {1'b0, target_q} - {1'b0, sample.adc_code};
		neg      = diff[ADC_BITS];
		mag      = neg ? (sample.adc_code - target_q) : diff[ADC_BITS-1:0];
		step_eff = (step_q == '0) ? ADC_BITS'(1) : step_q;
	end

	assign accept   = sample_valid && !sample_stall;
	assign out_free = !result_valid_q || !result_stall;

	// next state and sequencing
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		trim_we   = 1'b0;
		load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					if (phase_q == PH_ADJUST) begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end else begin
						state_d   = ST_LOAD;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					trim_we = 1'b1;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (out_free) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign sample_stall = (state_q != ST_IDLE);

	ltcl_sdiv u_sdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  (step_eff),
		.done     (div_done),
		.quotient (quot)
	);

	// saturated trim update from the quotient
	always_comb begin
		q_cap = (|quot[ADC_BITS-1:TRIM_BITS]) ? {1'b1, {TRIM_BITS{1'b0}}}
		                                       : {1'b0, quot[TRIM_BITS-1:0]};
		sum   = {1'b0, trim_q} + q_cap;
		if (!neg_q) begin
			trim_d = (sum > {1'b0, TRIM_MAX}) ? TRIM_MAX : sum[TRIM_BITS-1:0];
		end else begin
			trim_d = (q_cap >= {1'b0, trim_q}) ? '0 : (trim_q - q_cap[TRIM_BITS-1:0]);
		end
	end

	// result word
	always_comb begin
		merged = ldo_q;
		merged[TRIM_SHIFT +: TRIM_BITS] = trim_q;
		bmask  = (bin_q == BIN_MASKED) ? MASK_BIN2 : MASK_FULL;
		wr_en  = (bin_q == BIN_FULL) || (bin_q == BIN_MASKED);
		res_d  = '0;
		res_d.trim_value = trim_q;
		if (phase_q == PH_ADJUST) begin
			if (wr_en) begin
				res_d.write_valid = 1'b1;
				res_d.write_word  = {WRITE_KEY, merged & bmask};
			end
		end else begin
			if (mag_q < tol_q || mag_q == '0) begin
				res_d.done_res = 1'b1;
			end else if (trim_q == '0 || trim_q == TRIM_MAX) begin
				res_d.done_res = 1'b1;
				res_d.fail     = (mag_q > window_q);
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			phase_q        <= PH_ADJUST;
			trim_q         <= TRIM_RESET;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (trim_we) begin
				trim_q <= trim_d;
			end
			if (load) begin
				phase_q        <= (phase_q == PH_ADJUST) ? PH_CHECK : PH_ADJUST;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// sample capture and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= mag;
			neg_q <= neg;
			ldo_q <= sample.ldo_reg_now;
		end
		if (load) begin
			result_q <= res_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// divider runs only on adjust samples
	`ASSERT_IMPLIES(a_div_adjust, clk, arst_n, state_q == ST_DIV, phase_q == PH_ADJUST)
	// a failure is only reported as finished at a trim limit
	`ASSERT_IMPLIES(a_fail_limit, clk, arst_n, result_valid && result.fail, result.done_res && (result.trim_value == TRIM_MAX || result.trim_value == '0))
	// register writes come only from adjust steps, which never finish
	`ASSERT_IMPLIES(a_write_open, clk, arst_n, result_valid && result.write_valid, !result.done_res)
	// divider completion moves straight to result load
	`ASSERT_NEXT(a_div_load, clk, arst_n, state_q == ST_DIV && div_done, state_q == ST_LOAD)

endmodule
